@@ hdl/msld_pkg.sv @@
`timescale 1ns / 1ps

package msld_pkg;

    // longest address field, in bytes
    localparam logic [7:0] ADDR_WIDTH_LIMIT = 8'd255;
    // day-of-week and month fields
    localparam logic [7:0] SHORT_FIELD_LIMIT = 8'd3;

    typedef logic [4:0] t_phase;

    localparam t_phase PH_LEAD_F    = 5'd0;
    localparam t_phase PH_LEAD_R    = 5'd1;
    localparam t_phase PH_LEAD_O    = 5'd2;
    localparam t_phase PH_LEAD_M    = 5'd3;
    localparam t_phase PH_ADDR_PRE  = 5'd4;
    localparam t_phase PH_ADDR      = 5'd5;
    localparam t_phase PH_WDAY_PRE  = 5'd6;
    localparam t_phase PH_WDAY      = 5'd7;
    localparam t_phase PH_MON_PRE   = 5'd8;
    localparam t_phase PH_MON       = 5'd9;
    localparam t_phase PH_DAY_PRE   = 5'd10;
    localparam t_phase PH_DAY_SIGN  = 5'd11;
    localparam t_phase PH_DAY_DIG   = 5'd12;
    localparam t_phase PH_HOUR_PRE  = 5'd13;
    localparam t_phase PH_HOUR_SIGN = 5'd14;
    localparam t_phase PH_HOUR_DIG  = 5'd15;
    localparam t_phase PH_MIN_PRE   = 5'd16;
    localparam t_phase PH_MIN_SIGN  = 5'd17;
    localparam t_phase PH_MIN_DIG   = 5'd18;
    localparam t_phase PH_SEC_PRE   = 5'd19;
    localparam t_phase PH_SEC_SIGN  = 5'd20;
    localparam t_phase PH_SEC_DIG   = 5'd21;
    localparam t_phase PH_YEAR_PRE  = 5'd22;
    localparam t_phase PH_YEAR_SIGN = 5'd23;
    localparam t_phase PH_YEAR_DIG  = 5'd24;
    localparam t_phase PH_DONE      = 5'd25;

    typedef enum logic [2:0] {
        ADDR_LOCAL_START = 3'd0,
        ADDR_LOCAL       = 3'd1,
        ADDR_HOST_START  = 3'd2,
        ADDR_HOST        = 3'd3,
        ADDR_ERR         = 3'd4
    } t_addr_state;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  count;
        t_addr_state addr;
        logic        failed;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        phase:  PH_LEAD_F,
        count:  8'd0,
        addr:   ADDR_LOCAL_START,
        failed: 1'b0
    };

    typedef struct packed {
        t_scan_state st;
        logic        again;
    } t_adv;

    // control from the input stage to the scanner
    typedef struct packed {
        logic step;
        logic line_end;
    } t_scan_ctl;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_atext(input logic [7:0] c);
        logic r;
        case (c) inside
            [8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]: r = 1'b1;
            "!", "#", "$", "%", "&", 8'h27, "*", "+", "-", "/",
            "=", "?", "^", "_", 8'h60, "{", "|", "}", "~": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_addr_state addr_feed(input t_addr_state s, input logic [7:0] c);
        t_addr_state r;
        case (s)
            ADDR_LOCAL_START: r = is_atext(c) ? ADDR_LOCAL : ADDR_ERR;
            ADDR_LOCAL: begin
                if (is_atext(c)) r = ADDR_LOCAL;
                else if (c == ".") r = ADDR_LOCAL_START;
                else if (c == "@") r = ADDR_HOST_START;
                else r = ADDR_ERR;
            end
            ADDR_HOST_START: r = is_atext(c) ? ADDR_HOST : ADDR_ERR;
            ADDR_HOST: begin
                if (is_atext(c)) r = ADDR_HOST;
                else if (c == ".") r = ADDR_HOST_START;
                else r = ADDR_ERR;
            end
            default: r = ADDR_ERR;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] lead_char(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = "F";
            2'd1:    r = "r";
            2'd2:    r = "o";
            default: r = "m";
        endcase
        return r;
    endfunction

    // one step of the pattern; again set means the byte must be handled once more
    function automatic t_adv advance(input t_scan_state s, input logic [7:0] c);
        t_adv       r;
        logic [7:0] limit;
        r.st    = s;
        r.again = 1'b0;
        limit   = (s.phase == PH_ADDR) ? ADDR_WIDTH_LIMIT : SHORT_FIELD_LIMIT;
        case (s.phase) inside
            PH_LEAD_F, PH_LEAD_R, PH_LEAD_O, PH_LEAD_M: begin
                if (c == lead_char(s.phase[1:0])) r.st.phase = s.phase + 5'd1;
                else r.st.failed = 1'b1;
            end
            PH_ADDR_PRE, PH_WDAY_PRE, PH_MON_PRE: begin
                if (!is_ws(c)) begin
                    r.st.count = 8'd1;
                    r.st.phase = s.phase + 5'd1;
                    if (s.phase == PH_ADDR_PRE) r.st.addr = addr_feed(s.addr, c);
                end
            end
            PH_ADDR, PH_WDAY, PH_MON: begin
                if (is_ws(c)) begin
                    r.st.phase = s.phase + 5'd1;
                end else if (s.count < limit) begin
                    r.st.count = s.count + 8'd1;
                    if (s.phase == PH_ADDR) r.st.addr = addr_feed(s.addr, c);
                end else begin
                    // field full: the rest opens the next field
                    r.st.phase = s.phase + 5'd1;
                    r.again    = 1'b1;
                end
            end
            PH_DAY_PRE, PH_HOUR_PRE, PH_MIN_PRE, PH_SEC_PRE, PH_YEAR_PRE: begin
                if (is_ws(c)) r.st.phase = s.phase;
                else if ((c == "+") || (c == "-")) r.st.phase = s.phase + 5'd1;
                else if (is_digit(c)) r.st.phase = s.phase + 5'd2;
                else r.st.failed = 1'b1;
            end
            PH_DAY_SIGN, PH_HOUR_SIGN, PH_MIN_SIGN, PH_SEC_SIGN, PH_YEAR_SIGN: begin
                if (is_digit(c)) r.st.phase = s.phase + 5'd1;
                else r.st.failed = 1'b1;
            end
            PH_DAY_DIG, PH_SEC_DIG: begin
                if (!is_digit(c)) begin
                    r.st.phase = s.phase + 5'd1;
                    r.again    = 1'b1;
                end
            end
            PH_HOUR_DIG, PH_MIN_DIG: begin
                if (!is_digit(c)) begin
                    if (c == ":") r.st.phase = s.phase + 5'd1;
                    else r.st.failed = 1'b1;
                end
            end
            PH_YEAR_DIG: begin
                if (!is_digit(c)) r.st.phase = PH_DONE;
            end
            PH_DONE: r.st.phase = PH_DONE;
            default: r.st.failed = 1'b1;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/msld_scan.sv @@
`timescale 1ns / 1ps

module msld_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_char,
    input  msld_pkg::t_scan_ctl i_ctl,
    output logic                o_match
);

    msld_pkg::t_scan_state r_state;
    msld_pkg::t_scan_state n_state;
    msld_pkg::t_scan_state upd;
    msld_pkg::t_adv        adv1;
    msld_pkg::t_adv        adv2;

    always_comb begin
        adv1 = msld_pkg::advance(r_state, i_char);
        adv2 = msld_pkg::advance(adv1.st, i_char);
        upd  = r_state;
        if (!r_state.failed) begin
            if (i_char == 8'd0) begin
                // zero byte ends the text
                if (r_state.phase == msld_pkg::PH_YEAR_DIG) upd.phase = msld_pkg::PH_DONE;
                else if (r_state.phase != msld_pkg::PH_DONE) upd.failed = 1'b1;
            end else if (adv1.again && !adv1.st.failed) begin
                upd = adv2.st;
            end else begin
                upd = adv1.st;
            end
        end
        o_match = !upd.failed
                  && ((upd.phase == msld_pkg::PH_YEAR_DIG) || (upd.phase == msld_pkg::PH_DONE))
                  && ((upd.addr == msld_pkg::ADDR_LOCAL) || (upd.addr == msld_pkg::ADDR_HOST));
        n_state = r_state;
        if (i_ctl.step) begin
            n_state = i_ctl.line_end ? msld_pkg::SCAN_RESET : upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msld_pkg::SCAN_RESET;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/mbox_separator_line_detector.sv @@
`timescale 1ns / 1ps

// mbox separator line detector
// input channel: i_valid / o_stall with i_char_in and i_line_end, one byte of a
// text line per item; an item is taken at a clock edge with i_valid high and
// o_stall low. output channel: o_valid / i_stall with o_is_separator, one item
// per line, sent for the byte that carries i_line_end.
// a line end taken passes the input register, then the scan logic into the result
// register, which drives o_valid.
// throughput: one byte per cycle, set by the scan state update, unless stalled.
// when the receiver stalls, the result register holds; bytes that are not line
// ends keep flowing, and a second line end waits in the input register, raising
// o_stall, until the result is taken.
// reset (i_rst_n low at a clock edge) empties both registers and returns the
// scanner to the start of a line.
module mbox_separator_line_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_separator
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_end;
    logic       r_out_valid;
    logic       r_out_flag;

    logic                out_free;
    logic                s1_go;
    logic                in_accept;
    logic                scan_match;
    msld_pkg::t_scan_ctl scan_ctl;

    assign out_free  = !r_out_valid || !i_stall;
    assign s1_go     = r_in_valid && (!r_in_end || out_free);
    assign o_stall   = r_in_valid && !s1_go;
    assign in_accept = i_valid && !o_stall;

    assign scan_ctl.step     = s1_go;
    assign scan_ctl.line_end = r_in_end;

    msld_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (r_in_char),
        .i_ctl   (scan_ctl),
        .o_match (scan_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_in;
            r_in_end  <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_in_end) begin
            r_out_flag <= scan_match;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_separator = r_out_flag;

`ifndef SYNTHESIS
    // a result only comes from a line end leaving the input register
    a_result_from_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_end))
        else $error("result without a line end");

    // back pressure only for a line end blocked by a waiting result
    a_stall_only_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_in_end && r_out_valid && i_stall))
        else $error("input stalled without cause");

    // a waiting result is never dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule
